/* rtl/bpfa_pkg.sv */
package bpfa_pkg;

  localparam int NumFrames = 32768;
  localparam int WordBits = 32;
  localparam int MapWords = NumFrames / WordBits;
  localparam int WordAw = $clog2(MapWords);
  localparam int BitAw = $clog2(WordBits);
  localparam int FrameW = WordAw + BitAw;
  localparam int CountW = $clog2(NumFrames + 1);
  localparam int GrpBits = 32;
  localparam int NumGrps = MapWords / GrpBits;
  localparam int GrpAw = (NumGrps > 1) ? $clog2(NumGrps) : 1;
  localparam logic [15:0] ReservedReset = 16'd2048;

  localparam logic [1:0] CmdAlloc = 2'd0;
  localparam logic [1:0] CmdFree = 2'd1;
  localparam logic [1:0] CmdInit = 2'd2;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StOom = 2'd1;
  localparam logic [1:0] StIgnored = 2'd2;
  localparam logic [1:0] StInit = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_GSCAN,
    S_SWAIT,
    S_MREAD,
    S_MWAIT,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clear_start;
    logic clear_step;
    logic sum_read;
    logic map_read;
    logic latch_sum;
    logic map_write;
    logic finish;
    logic oom;
    logic ignore;
  } ctrl_t;

  typedef struct packed {
    logic clear_last;
    logic grp_found;
    logic is_alloc;
    logic is_free;
    logic is_init;
    logic free_ok;
    logic bit_set;
  } stat_t;

  function automatic logic [BitAw-1:0] lowest_zero(input logic [WordBits-1:0] w);
    logic [BitAw-1:0] r;
    r = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (!w[i]) r = BitAw'(i);
    end
    return r;
  endfunction

endpackage

/* rtl/bpfa_ctrl.sv */
module bpfa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bpfa_pkg::stat_t st,
  output logic            busy,
  output bpfa_pkg::ctrl_t ctl
);

  bpfa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= bpfa_pkg::S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    busy = 1'b1;
    case (state)
      bpfa_pkg::S_CLEAR: begin
        ctl.clear_step = 1'b1;
        if (st.clear_last) state_next = bpfa_pkg::S_IDLE;
      end
      bpfa_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) state_next = bpfa_pkg::S_GSCAN;
      end
      bpfa_pkg::S_GSCAN: begin
        if (st.is_init) begin
          ctl.clear_start = 1'b1;
          state_next = bpfa_pkg::S_CLEAR;
        end else if (st.is_alloc) begin
          if (st.grp_found) begin
            ctl.sum_read = 1'b1;
            state_next = bpfa_pkg::S_SWAIT;
          end else begin
            ctl.oom = 1'b1;
            state_next = bpfa_pkg::S_DONE;
          end
        end else if (st.is_free && st.free_ok) begin
          // summary word is needed too, the write-back updates it
          ctl.sum_read = 1'b1;
          ctl.map_read = 1'b1;
          state_next = bpfa_pkg::S_MWAIT;
        end else begin
          ctl.ignore = 1'b1;
          state_next = bpfa_pkg::S_DONE;
        end
      end
      bpfa_pkg::S_SWAIT: begin
        ctl.latch_sum = 1'b1;
        state_next = bpfa_pkg::S_MREAD;
      end
      bpfa_pkg::S_MREAD: begin
        ctl.map_read = 1'b1;
        state_next = bpfa_pkg::S_MWAIT;
      end
      bpfa_pkg::S_MWAIT: begin
        if (st.is_free && !st.bit_set) begin
          ctl.ignore = 1'b1;
          state_next = bpfa_pkg::S_DONE;
        end else begin
          state_next = bpfa_pkg::S_WRITE;
        end
      end
      bpfa_pkg::S_WRITE: begin
        ctl.map_write = 1'b1;
        state_next = bpfa_pkg::S_DONE;
      end
      bpfa_pkg::S_DONE: begin
        ctl.finish = 1'b1;
        state_next = bpfa_pkg::S_IDLE;
      end
      default: state_next = bpfa_pkg::S_CLEAR;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == bpfa_pkg::S_IDLE && start) |=> state == bpfa_pkg::S_GSCAN)
    else $error("command not taken");
  assert property (@(posedge clk) disable iff (rst)
    ctl.finish |=> !busy)
    else $error("not idle after result");
  assert property (@(posedge clk) disable iff (rst)
    ctl.map_write |=> ctl.finish)
    else $error("write not followed by result");

endmodule

/* rtl/bpfa_dpath.sv */
module bpfa_dpath (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  logic [1:0]      command,
  input  logic [19:0]     frame_number,
  input  logic            reserved_frames_we,
  input  logic [15:0]     reserved_frames_wdata,
  input  bpfa_pkg::ctrl_t ctl,
  output bpfa_pkg::stat_t st,
  output logic            done,
  output logic [1:0]      status,
  output logic [14:0]     allocated_frame,
  output logic [15:0]     used_frames,
  output logic [15:0]     free_frames
);

  localparam int Aw = bpfa_pkg::WordAw;
  localparam int Bw = bpfa_pkg::BitAw;
  localparam int Wb = bpfa_pkg::WordBits;
  localparam int Cw = bpfa_pkg::CountW;
  localparam int Gw = bpfa_pkg::GrpAw;
  localparam int Ng = bpfa_pkg::NumGrps;
  localparam int Sw = Aw - Gw;

  logic [Wb-1:0] map_mem [bpfa_pkg::MapWords];
  logic [bpfa_pkg::GrpBits-1:0] sum_mem [Ng];
  logic [Ng-1:0] grp_full;

  logic [15:0] reserved;
  logic [Cw-1:0] used_count;
  logic [1:0] cmd;
  logic fnum_oor;
  logic [Aw-1:0] clr_addr;
  logic [Cw-1:0] clr_n;
  logic [Gw-1:0] grp;
  logic [Gw-1:0] free_grp;
  logic [Aw-1:0] waddr;
  logic [Bw-1:0] bidx;
  logic [Wb-1:0] rd_word;
  logic [bpfa_pkg::GrpBits-1:0] rd_sum;
  logic [Wb-1:0] new_word;
  logic [bpfa_pkg::GrpBits-1:0] new_sum;
  logic [Cw-1:0] base;
  logic [Wb-1:0] clr_word;
  logic [Cw-1:0] res_sat;
  logic init_pend;
  logic [1:0] st_code;
  logic [1:0] st_hold;

  always_comb begin
    res_sat = (reserved > 16'(bpfa_pkg::NumFrames)) ? Cw'(bpfa_pkg::NumFrames)
                                                    : Cw'(reserved);
  end

  always_ff @(posedge clk) begin
    if (rst) reserved <= bpfa_pkg::ReservedReset;
    else if (reserved_frames_we) reserved <= reserved_frames_wdata;
  end

  // clearing pass: words below reservation full, boundary partial
  always_comb begin
    base = Cw'({clr_addr, Bw'(0)});
    if (clr_n >= base + Cw'(Wb)) clr_word = '1;
    else if (clr_n <= base) clr_word = '0;
    else clr_word = ~({Wb{1'b1}} << Bw'(clr_n - base));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clr_n <= (bpfa_pkg::ReservedReset > 16'(bpfa_pkg::NumFrames))
               ? Cw'(bpfa_pkg::NumFrames) : Cw'(bpfa_pkg::ReservedReset);
    end else if (ctl.clear_start) begin
      clr_addr <= '0;
      clr_n <= res_sat;
    end else if (ctl.clear_step) begin
      clr_addr <= clr_addr + Aw'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear_step) map_mem[clr_addr] <= clr_word;
    else if (ctl.map_write) map_mem[waddr] <= new_word;
    if (ctl.map_read) rd_word <= map_mem[waddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.clear_step) sum_mem[clr_addr[Aw-1 -: Gw]][clr_addr[Sw-1:0]] <= &clr_word;
    else if (ctl.map_write) sum_mem[grp] <= new_sum;
    if (ctl.sum_read) rd_sum <= sum_mem[grp];
  end

  always_ff @(posedge clk) begin
    if (rst) grp_full <= '0;
    else if (ctl.clear_step) begin
      if (clr_addr[Sw-1:0] == Sw'(0)) grp_full[clr_addr[Aw-1 -: Gw]] <= &clr_word;
      else grp_full[clr_addr[Aw-1 -: Gw]] <= grp_full[clr_addr[Aw-1 -: Gw]] & (&clr_word);
    end else if (ctl.map_write) grp_full[grp] <= &new_sum;
  end

  always_comb begin
    new_word = rd_word;
    new_word[bidx] = cmd == bpfa_pkg::CmdAlloc;
    new_sum = rd_sum;
    new_sum[waddr[Sw-1:0]] = &new_word;
  end

  // lowest group that still has a free word
  always_comb begin
    free_grp = '0;
    for (int g = Ng - 1; g >= 0; g--) begin
      if (!grp_full[g]) free_grp = Gw'(g);
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd <= command;
      fnum_oor <= frame_number >= 20'(bpfa_pkg::NumFrames);
      waddr <= frame_number[bpfa_pkg::FrameW-1:Bw];
      bidx <= frame_number[Bw-1:0];
      if (command == bpfa_pkg::CmdAlloc) grp <= free_grp;
      else grp <= frame_number[bpfa_pkg::FrameW-1 -: Gw];
    end else if (ctl.latch_sum) begin
      waddr <= {grp, Sw'(bpfa_pkg::lowest_zero(rd_sum))};
    end else if (st.is_alloc && !ctl.map_write && !ctl.finish) begin
      bidx <= bpfa_pkg::lowest_zero(rd_word);
    end
  end

  assign st.clear_last = clr_addr == Aw'(bpfa_pkg::MapWords - 1);
  assign st.grp_found = !(&grp_full);
  assign st.is_alloc = cmd == bpfa_pkg::CmdAlloc;
  assign st.is_free = cmd == bpfa_pkg::CmdFree;
  assign st.is_init = cmd == bpfa_pkg::CmdInit;
  assign st.free_ok = !fnum_oor;
  assign st.bit_set = rd_word[bidx];

  always_ff @(posedge clk) begin
    if (rst) used_count <= (bpfa_pkg::ReservedReset > 16'(bpfa_pkg::NumFrames))
                           ? Cw'(bpfa_pkg::NumFrames) : Cw'(bpfa_pkg::ReservedReset);
    else if (ctl.clear_start) used_count <= res_sat;
    else if (ctl.map_write) begin
      if (st.is_alloc) used_count <= used_count + Cw'(1);
      else if (used_count != '0) used_count <= used_count - Cw'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) init_pend <= 1'b0;
    else if (ctl.clear_start) init_pend <= 1'b1;
    else if (ctl.clear_step && st.clear_last) init_pend <= 1'b0;
  end

  always_comb begin
    if (ctl.oom) st_code = bpfa_pkg::StOom;
    else if (ctl.ignore) st_code = bpfa_pkg::StIgnored;
    else st_code = bpfa_pkg::StOk;
  end

  always_ff @(posedge clk) begin
    if (rst) st_hold <= bpfa_pkg::StOk;
    else if (start && !busy) st_hold <= bpfa_pkg::StOk;
    else if (ctl.oom || ctl.ignore) st_hold <= st_code;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= ctl.finish || (init_pend && ctl.clear_step && st.clear_last);
  end

  always_ff @(posedge clk) begin
    if (ctl.finish || (init_pend && ctl.clear_step && st.clear_last)) begin
      if (init_pend) status <= bpfa_pkg::StInit;
      else status <= st_hold;
      allocated_frame <= (st.is_alloc && st_hold == bpfa_pkg::StOk && !init_pend)
                         ? 15'({waddr, bidx}) : 15'd0;
      used_frames <= 16'(used_count);
      free_frames <= 16'(Cw'(bpfa_pkg::NumFrames) - used_count);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    done |-> used_frames + free_frames == 16'(bpfa_pkg::NumFrames))
    else $error("counts disagree");
  assert property (@(posedge clk) disable iff (rst)
    (done && status == bpfa_pkg::StOk && st.is_alloc) |-> $past(ctl.map_write, 2))
    else $error("grant without write");
  assert property (@(posedge clk) disable iff (rst)
    used_count <= Cw'(bpfa_pkg::NumFrames))
    else $error("count overflow");

endmodule

/* rtl/bitmap_page_frame_allocator_core.sv */
// first-fit page frame allocator over a 32768-frame used-bit map held in a
// 1024x32 memory, with a 32x32 word-full summary memory and one group-full
// flip-flop per summary word. a command transfer happens when start is high
// and busy low; exactly one result follows, shown for one cycle with done
// high, and the receiver cannot stall it. an allocate reads the summary, then
// the map, then does the read-modify-write, but skips all of these when out
// of memory; a free reads summary and map together, then writes back, skips
// the write when the frame is already clear and both reads when out of
// range; an unused command is answered without any access. busy drops in
// the result cycle, so the next transfer can happen at its end. init, and
// reset, run a clearing pass that writes each of the 1024 map words in turn,
// with busy high; the init result follows the write of the last map word.
// reserved_frames may be written at any idle time and applies at the
// next init.
module bitmap_page_frame_allocator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [19:0] frame_number,
  input  logic        reserved_frames_we,
  input  logic [15:0] reserved_frames_wdata,
  output logic        done,
  output logic [1:0]  status,
  output logic [14:0] allocated_frame,
  output logic [15:0] used_frames,
  output logic [15:0] free_frames
);

  // command and status path between sequencer and map datapath
  bpfa_pkg::ctrl_t ctl;
  bpfa_pkg::stat_t st;

  bpfa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .busy  (busy),
    .ctl   (ctl)
  );

  bpfa_dpath u_dpath (
    .clk                   (clk),
    .rst                   (rst),
    .start                 (start),
    .busy                  (busy),
    .command               (command),
    .frame_number          (frame_number),
    .reserved_frames_we    (reserved_frames_we),
    .reserved_frames_wdata (reserved_frames_wdata),
    .ctl                   (ctl),
    .st                    (st),
    .done                  (done),
    .status                (status),
    .allocated_frame       (allocated_frame),
    .used_frames           (used_frames),
    .free_frames           (free_frames)
  );

endmodule

/* tb/sv/bitmap_page_frame_allocator_core_tb.sv */
`timescale 1ns / 100ps

module bitmap_page_frame_allocator_core_tb;

  localparam int TotalFrames = 32768;
  localparam int CmdUnused = 3;
  localparam int WatchdogLimit = 20000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [19:0] frame;
  } frame_cmd_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [14:0] granted;
    logic [15:0] used;
    logic [15:0] avail;
  } frame_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  command;
  logic [19:0] frame_number;
  logic        reserved_frames_we;
  logic [15:0] reserved_frames_wdata;
  logic        done;
  logic [1:0]  status;
  logic [14:0] allocated_frame;
  logic [15:0] used_frames;
  logic [15:0] free_frames;

  // shadow of the used-bit map, the count and the reservation register
  bit [TotalFrames-1:0] shadow_map;
  int unsigned          shadow_used;
  int unsigned          shadow_reserved;

  frame_cmd_t    pending_cmds[$];
  frame_result_t expected_results[$];
  int            error_count;
  int            idle_cycles;
  int            gap_left;
  bit            gaps_on;
  bit            stim_done;
  int            n_alloc, n_free, n_init, n_oom, n_ignored;

  bitmap_page_frame_allocator_core u_dut (
    .clk                   (clk),
    .rst                   (rst),
    .start                 (start),
    .busy                  (busy),
    .command               (command),
    .frame_number          (frame_number),
    .reserved_frames_we    (reserved_frames_we),
    .reserved_frames_wdata (reserved_frames_wdata),
    .done                  (done),
    .status                (status),
    .allocated_frame       (allocated_frame),
    .used_frames           (used_frames),
    .free_frames           (free_frames)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // rebuild the map as init does: low frames reserved, saturated at the total
  function automatic void shadow_init();
    int unsigned n;
    n = (shadow_reserved > TotalFrames) ? TotalFrames : shadow_reserved;
    shadow_map = '0;
    for (int f = 0; f < n; f++) shadow_map[f] = 1'b1;
    shadow_used = n;
  endfunction

  // work out the result of one command and update the shadow state
  function automatic frame_result_t predict_frame_cmd(frame_cmd_t c);
    frame_result_t r;
    bit found;
    r = '0;
    found = 1'b0;
    if (c.cmd == bpfa_pkg::CmdAlloc) begin
      n_alloc++;
      for (int f = 0; f < TotalFrames && !found; f++) begin
        if (!shadow_map[f]) begin
          shadow_map[f] = 1'b1;
          shadow_used++;
          r.granted = f[14:0];
          found = 1'b1;
        end
      end
      r.st = found ? bpfa_pkg::StOk : bpfa_pkg::StOom;
      if (!found) n_oom++;
    end else if (c.cmd == bpfa_pkg::CmdFree) begin
      n_free++;
      if (c.frame < TotalFrames && shadow_map[c.frame]) begin
        shadow_map[c.frame] = 1'b0;
        if (shadow_used > 0) shadow_used--;
        r.st = bpfa_pkg::StOk;
      end else begin
        r.st = bpfa_pkg::StIgnored;
        n_ignored++;
      end
    end else if (c.cmd == bpfa_pkg::CmdInit) begin
      n_init++;
      shadow_init();
      r.st = bpfa_pkg::StInit;
    end else begin
      r.st = bpfa_pkg::StIgnored;
    end
    r.used  = shadow_used[15:0];
    r.avail = 16'(TotalFrames - shadow_used);
    return r;
  endfunction

  // driver: one command per transfer, random gap bursts while enabled
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && !busy) begin
      // transfer taken at this edge; decide on the next one
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        gap_left <= $urandom_range(1, 8);
      end else if (pending_cmds.size() > 0) begin
        command <= pending_cmds[0].cmd;
        frame_number <= pending_cmds[0].frame;
        expected_results.push_back(predict_frame_cmd(pending_cmds.pop_front()));
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_cmds.size() > 0) begin
        start <= 1'b1;
        command <= pending_cmds[0].cmd;
        frame_number <= pending_cmds[0].frame;
        expected_results.push_back(predict_frame_cmd(pending_cmds.pop_front()));
      end
    end
  end

  // monitor: done is a one-cycle strobe, compare against the oldest expectation
  always @(posedge clk) begin
    frame_result_t e;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with no command outstanding");
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (status !== e.st) begin
          $error("status: expected %0d actual %0d", e.st, status);
          error_count++;
        end
        if (allocated_frame !== e.granted) begin
          $error("allocated_frame: expected %0d actual %0d", e.granted, allocated_frame);
          error_count++;
        end
        if (used_frames !== e.used) begin
          $error("used_frames: expected %0d actual %0d", e.used, used_frames);
          error_count++;
        end
        if (free_frames !== e.avail) begin
          $error("free_frames: expected %0d actual %0d", e.avail, free_frames);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer or result; covers the clearing pass
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired");
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // wait until every queued command has been transferred and answered
  task automatic drain();
    while (pending_cmds.size() > 0 || start || gap_left > 0 ||
           expected_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write the reservation register while the block is idle
  task automatic write_reserved(int unsigned value);
    reserved_frames_we <= 1'b1;
    reserved_frames_wdata <= value[15:0];
    @(posedge clk);
    reserved_frames_we <= 1'b0;
    shadow_reserved = value & 16'hFFFF;
  endtask

  function automatic void queue_cmd(int c, int unsigned f);
    frame_cmd_t x;
    x.cmd = c[1:0];
    x.frame = f[19:0];
    pending_cmds.push_back(x);
  endfunction

  // random free target: mostly a frame near the allocation front
  function automatic int unsigned pick_frame(int unsigned front);
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 20'hFFFFF);
      1: return $urandom_range(TotalFrames, 20'hFFFFF);
      2: return $urandom_range(0, TotalFrames - 1);
      default: return (front > 40) ? $urandom_range(front - 40, front + 8) :
                                     $urandom_range(0, front + 8);
    endcase
  endfunction

  // a phase of random commands, allocations and frees dominating
  task automatic random_phase(int count, int unsigned front);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 50) queue_cmd(bpfa_pkg::CmdAlloc, 0);
      else if (k < 95) queue_cmd(bpfa_pkg::CmdFree, pick_frame(front + i / 2));
      else if (k < 97) queue_cmd(CmdUnused, $urandom);
      else queue_cmd(bpfa_pkg::CmdInit, $urandom);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    command = '0;
    frame_number = '0;
    reserved_frames_we = 1'b0;
    reserved_frames_wdata = '0;
    error_count = 0;
    gaps_on = 1'b1;
    stim_done = 1'b0;
    shadow_reserved = bpfa_pkg::ReservedReset;
    shadow_init();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: reset state, every command, field extremes
    queue_cmd(bpfa_pkg::CmdAlloc, 0);
    queue_cmd(bpfa_pkg::CmdAlloc, 20'hFFFFF);
    queue_cmd(bpfa_pkg::CmdFree, 2048);
    queue_cmd(bpfa_pkg::CmdFree, 2048);
    queue_cmd(bpfa_pkg::CmdFree, 0);
    queue_cmd(bpfa_pkg::CmdFree, 0);
    queue_cmd(bpfa_pkg::CmdFree, TotalFrames - 1);
    queue_cmd(bpfa_pkg::CmdFree, TotalFrames);
    queue_cmd(bpfa_pkg::CmdFree, 20'hFFFFF);
    queue_cmd(bpfa_pkg::CmdFree, 20'h55555);
    queue_cmd(bpfa_pkg::CmdFree, 20'h2AAAA);
    queue_cmd(CmdUnused, 20'hFFFFF);
    queue_cmd(bpfa_pkg::CmdAlloc, 0);
    queue_cmd(bpfa_pkg::CmdAlloc, 0);
    queue_cmd(bpfa_pkg::CmdInit, 0);
    queue_cmd(bpfa_pkg::CmdAlloc, 0);
    drain();

    // full map: reserve everything, allocate into oom, free last frame, reallocate
    write_reserved(TotalFrames);
    queue_cmd(bpfa_pkg::CmdInit, 0);
    queue_cmd(bpfa_pkg::CmdAlloc, 0);
    queue_cmd(bpfa_pkg::CmdFree, TotalFrames - 1);
    queue_cmd(bpfa_pkg::CmdAlloc, 0);
    queue_cmd(bpfa_pkg::CmdAlloc, 0);
    queue_cmd(bpfa_pkg::CmdFree, 12345);
    queue_cmd(bpfa_pkg::CmdAlloc, 0);
    drain();

    // over-reservation saturates; then nothing reserved
    write_reserved(16'hFFFF);
    queue_cmd(bpfa_pkg::CmdInit, 0);
    queue_cmd(bpfa_pkg::CmdAlloc, 0);
    drain();
    write_reserved(0);
    queue_cmd(bpfa_pkg::CmdInit, 0);
    queue_cmd(bpfa_pkg::CmdAlloc, 0);
    queue_cmd(bpfa_pkg::CmdFree, 0);
    drain();

    // random phases over several reservations
    write_reserved(0);
    queue_cmd(bpfa_pkg::CmdInit, 0);
    random_phase(400, 0);
    drain();
    write_reserved(TotalFrames - 30);
    queue_cmd(bpfa_pkg::CmdInit, 0);
    random_phase(400, TotalFrames - 30);
    drain();
    write_reserved($urandom_range(1, TotalFrames - 1));
    queue_cmd(bpfa_pkg::CmdInit, 0);
    random_phase(450, shadow_reserved);
    drain();
    write_reserved(16'h8001 | $urandom_range(0, 16'h7FFE));
    queue_cmd(bpfa_pkg::CmdInit, 0);
    random_phase(100, TotalFrames);
    drain();

    // last part back to back, no gaps
    gaps_on = 1'b0;
    write_reserved(bpfa_pkg::ReservedReset);
    queue_cmd(bpfa_pkg::CmdInit, 0);
    random_phase(400, bpfa_pkg::ReservedReset);
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d allocates (%0d out of memory), %0d frees (%0d ignored), %0d inits",
             n_alloc, n_oom, n_free, n_ignored, n_init);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* bitmap_page_frame_allocator_core.f */
rtl/bpfa_pkg.sv
rtl/bpfa_ctrl.sv
rtl/bpfa_dpath.sv
rtl/bitmap_page_frame_allocator_core.sv
tb/sv/bitmap_page_frame_allocator_core_tb.sv
